@@ rtl/aso_pkg.sv @@
// ----------------------------------------------------------------------------
// aso_pkg: shared definitions for the additive sine oscillator
// Sizes, register and request codes, state type, configuration struct and
// the constant one-period sine table built at elaboration.
// ----------------------------------------------------------------------------
package aso_pkg;

    // Sizes
    localparam int PARTIALS   = 8;
    localparam int TABLE_BITS = 10;
    localparam int ROM_SIZE   = 1 << TABLE_BITS;
    localparam int QUARTER    = ROM_SIZE >> 2;

    localparam int AW      = (PARTIALS > 1) ? $clog2(PARTIALS) : 1;
    localparam int KW      = $clog2(PARTIALS + 1);
    localparam int KSTEP_W = 32 + KW;
    localparam int ACC_W   = 32 + $clog2(PARTIALS);
    localparam int P1_W    = ACC_W + 17;
    localparam int N_W     = P1_W - 15;
    localparam int P2_W    = N_W + 17;
    localparam int V_W     = P2_W - 30;

    // APB map
    localparam int ADDR_W = 4;

    localparam logic [1:0] REG_PHASE_STEP = 2'd0;
    localparam logic [1:0] REG_OUT_GAIN   = 2'd1;
    localparam logic [1:0] REG_NORM_GAIN  = 2'd2;

    // Request codes
    localparam logic [1:0] REQ_TICK      = 2'd0;
    localparam logic [1:0] REQ_WRITE_AMP = 2'd1;
    localparam logic [1:0] REQ_CLEAR     = 2'd2;

    // Fixed values
    localparam logic [15:0]        UNITY_Q15  = 16'd32768;
    localparam logic signed [15:0] SAMPLE_MAX = 16'sh7FFF;
    localparam logic signed [15:0] SAMPLE_MIN = 16'sh8000;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] ONE_Q30     = 64'd1073741824;

    typedef struct packed {
        logic [31:0] phase_step;
        logic [15:0] out_gain;
        logic [15:0] norm_gain;
    } t_cfg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN,
        ST_NORM,
        ST_GAIN,
        ST_OUT
    } t_state;

    typedef logic signed [15:0] t_sine_rom [ROM_SIZE];

    // Sine of (pi/2 * r / QUARTER) as Q1.15 magnitude, Taylor series in Q30
    function automatic logic [15:0] quarter_sine(input int unsigned r);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] v;
        x    = (HALF_PI_Q30 * 64'(r)) / QUARTER;
        x2   = (x * x) >> 30;
        term = x;
        sum  = x;
        term = ((term * x2) >> 30) / 64'd6;   sum = sum - term;
        term = ((term * x2) >> 30) / 64'd20;  sum = sum + term;
        term = ((term * x2) >> 30) / 64'd42;  sum = sum - term;
        term = ((term * x2) >> 30) / 64'd72;  sum = sum + term;
        term = ((term * x2) >> 30) / 64'd110; sum = sum - term;
        term = ((term * x2) >> 30) / 64'd156; sum = sum + term;
        term = ((term * x2) >> 30) / 64'd210; sum = sum - term;
        term = ((term * x2) >> 30) / 64'd272; sum = sum + term;
        term = ((term * x2) >> 30) / 64'd342; sum = sum - term;
        term = ((term * x2) >> 30) / 64'd420; sum = sum + term;
        v = (sum * 64'd32767 + (ONE_Q30 >> 1)) >> 30;
        if (v > 64'd32767) begin
            v = 64'd32767;
        end
        return v[15:0];
    endfunction

    // Full period by quarter-wave symmetry
    function automatic t_sine_rom build_sine_rom();
        t_sine_rom   rom;
        int unsigned q;
        int unsigned r;
        logic [15:0] m;
        for (int unsigned i = 0; i < ROM_SIZE; i++) begin
            q = i / QUARTER;
            r = i % QUARTER;
            m = ((q & 1) != 0) ? quarter_sine(QUARTER - r) : quarter_sine(r);
            rom[i] = ((q & 2) != 0) ? -$signed(m) : $signed(m);
        end
        return rom;
    endfunction

    localparam t_sine_rom SINE_ROM = build_sine_rom();

endpackage

@@ rtl/aso_if.sv @@
// ----------------------------------------------------------------------------
// aso_if: request and result channels of the additive sine oscillator
// Valid/ready channels; an item moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface aso_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [3:0]  partial_index;
    logic [15:0] amplitude_value;

    modport source(output valid, output req_type, output partial_index,
                   output amplitude_value, input ready);
    modport sink(input valid, input req_type, input partial_index,
                 input amplitude_value, output ready);
endinterface

interface aso_res_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample;
    logic [3:0]         partials_used;
    logic               saturated;

    modport source(output valid, output sample, output partials_used,
                   output saturated, input ready);
    modport sink(input valid, input sample, input partials_used,
                 input saturated, output ready);
endinterface

@@ rtl/aso_apb_regs.sv @@
// ----------------------------------------------------------------------------
// aso_apb_regs: configuration registers behind an APB-style port
// Holds phase step, output gain and normalization gain; reads back values.
// ----------------------------------------------------------------------------
module aso_apb_regs
    import aso_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg        r_cfg;
    logic        w_wr;
    logic [1:0]  w_reg;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_reg  = paddr[3:2];

    // Write on the access cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.phase_step <= '0;
            r_cfg.out_gain   <= UNITY_Q15;
            r_cfg.norm_gain  <= UNITY_Q15;
        end else if (w_wr) begin
            case (w_reg)
                REG_PHASE_STEP: r_cfg.phase_step <= pwdata;
                REG_OUT_GAIN:   r_cfg.out_gain   <= pwdata[15:0];
                REG_NORM_GAIN:  r_cfg.norm_gain  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        case (w_reg)
            REG_PHASE_STEP: prdata = r_cfg.phase_step;
            REG_OUT_GAIN:   prdata = {16'd0, r_cfg.out_gain};
            REG_NORM_GAIN:  prdata = {16'd0, r_cfg.norm_gain};
            default:        prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

@@ rtl/additive_sine_oscillator.sv @@
// ----------------------------------------------------------------------------
// additive_sine_oscillator: sum of harmonic sines below the Nyquist cutoff
// Usage:
//   i_req carries requests: a sample tick, an amplitude write for one
//   harmonic, or a clear of all harmonic phases. o_res carries one result
//   (sample, partials_used, saturated) for each tick; writes, clears and
//   unknown request types give none. The APB port sets phase step and the
//   two gains; write it only while no tick is in flight.
//   Sequence: writes and clears complete on acceptance. For a tick, the
//   harmonic loop reads the phase and amplitude memories once per cycle
//   for each harmonic below the cutoff, then three pipeline stages drain
//   and two multiply stages scale the sum. One tick is in work at a time,
//   so no further request is accepted until its result is loaded.
//   The result register lets the next request be accepted while a result
//   waits; if the receiver stalls, a finished tick holds in its last step
//   until the result register frees up.
//   Reset: phases read as zero, harmonic 1 amplitude as unity, the rest as
//   zero, both gains unity and phase step zero; no clearing pass is needed.
// ----------------------------------------------------------------------------
module additive_sine_oscillator
    import aso_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    aso_req_if.sink           i_req,
    aso_res_if.source         o_res
);

    t_cfg w_cfg;

    aso_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // State and control
    t_state r_state;
    t_state n_state;

    logic               w_accept;
    logic               w_tick;
    logic               w_req_ready;
    logic               w_issue;
    logic               w_pipe_empty;
    logic               w_out_free;
    logic               w_load_out;
    logic               w_amp_we;
    logic [AW-1:0]      w_amp_wa;

    logic [KW-1:0]      r_k;
    logic [KSTEP_W-1:0] r_kstep;

    // Memories and valid bits
    logic [31:0]        r_phase_mem [PARTIALS];
    logic [15:0]        r_amp_mem   [PARTIALS];
    logic [PARTIALS-1:0] r_ph_vld;
    logic [PARTIALS-1:0] r_amp_vld;
    logic [31:0]        r_ph_rd;
    logic [15:0]        r_amp_rd;

    // Pipeline
    logic               r_s1_valid;
    logic [AW-1:0]      r_s1_addr;
    logic [31:0]        r_s1_kstep;
    logic [31:0]        w_ph_eff;
    logic [15:0]        w_amp_eff;
    logic               r_s2_valid;
    logic [15:0]        r_s2_amp;
    logic signed [15:0] r_sine;
    logic               r_s3_valid;
    logic signed [31:0] r_prod;
    logic signed [ACC_W-1:0] r_acc;

    // Scaling
    logic signed [P1_W-1:0] r_p1;
    logic signed [N_W-1:0]  w_n;
    logic signed [P2_W-1:0] r_p2;
    logic signed [V_W-1:0]  w_v;
    logic [V_W-16:0]        w_v_hi;
    logic                   w_sat;
    logic signed [15:0]     w_sample;

    // Output register
    logic               r_out_valid;
    logic signed [15:0] r_out_sample;
    logic [3:0]         r_out_used;
    logic               r_out_sat;

    assign w_accept   = i_req.valid && w_req_ready;
    assign w_tick     = w_accept && (i_req.req_type == REQ_TICK);
    assign w_out_free = !r_out_valid || o_res.ready;
    assign w_pipe_empty = !r_s1_valid && !r_s2_valid && !r_s3_valid;
    assign w_issue    = (r_state == ST_ISSUE) && (r_k < KW'(PARTIALS))
                        && (r_kstep[KSTEP_W-1:31] == '0);

    assign w_amp_we = w_accept && (i_req.req_type == REQ_WRITE_AMP)
                      && (i_req.partial_index != 4'd0)
                      && (32'(i_req.partial_index) <= PARTIALS);
    assign w_amp_wa = AW'(i_req.partial_index - 4'd1);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (w_tick) n_state = ST_ISSUE;
            ST_ISSUE: if (!w_issue) n_state = ST_DRAIN;
            ST_DRAIN: if (w_pipe_empty) n_state = ST_NORM;
            ST_NORM:  n_state = ST_GAIN;
            ST_GAIN:  n_state = ST_OUT;
            ST_OUT:   if (w_out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        w_req_ready = 1'b0;
        w_load_out  = 1'b0;
        case (r_state)
            ST_IDLE: w_req_ready = 1'b1;
            ST_OUT:  w_load_out  = w_out_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Harmonic counter and running k times step
    always_ff @(posedge i_clk) begin
        if (w_tick) begin
            r_k     <= '0;
            r_kstep <= KSTEP_W'(w_cfg.phase_step);
        end else if (w_issue) begin
            r_k     <= r_k + KW'(1);
            r_kstep <= r_kstep + KSTEP_W'(w_cfg.phase_step);
        end
    end

    // Amplitude memory: write on request, read per issued harmonic
    always_ff @(posedge i_clk) begin
        if (w_amp_we) begin
            r_amp_mem[w_amp_wa] <= i_req.amplitude_value;
        end
        r_amp_rd <= r_amp_mem[r_k[AW-1:0]];
    end

    // Phase memory: read on issue, write back the advanced phase in stage 1
    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_phase_mem[r_s1_addr] <= w_ph_eff + r_s1_kstep;
        end
        r_ph_rd <= r_phase_mem[r_k[AW-1:0]];
    end

    // Valid bits stand in for reset of both memories and clear of the phases
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph_vld  <= '0;
            r_amp_vld <= '0;
        end else begin
            if (w_accept && (i_req.req_type == REQ_CLEAR)) begin
                r_ph_vld <= '0;
            end else if (r_s1_valid) begin
                r_ph_vld[r_s1_addr] <= 1'b1;
            end
            if (w_amp_we) begin
                r_amp_vld[w_amp_wa] <= 1'b1;
            end
        end
    end

    // Stage 1: resolve read data against valid bits
    always_comb begin
        w_ph_eff = r_ph_vld[r_s1_addr] ? r_ph_rd : 32'd0;
        if (r_amp_vld[r_s1_addr]) begin
            w_amp_eff = r_amp_rd;
        end else begin
            w_amp_eff = (r_s1_addr == '0) ? UNITY_Q15 : 16'd0;
        end
    end

    // Pipeline valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else begin
            r_s1_valid <= w_issue;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
        end
    end

    // Pipeline payload: sine lookup, product, accumulate
    always_ff @(posedge i_clk) begin
        r_s1_addr  <= r_k[AW-1:0];
        r_s1_kstep <= r_kstep[31:0];
        r_sine     <= SINE_ROM[w_ph_eff[31 -: TABLE_BITS]];
        r_s2_amp   <= w_amp_eff;
        r_prod     <= $signed({1'b0, r_s2_amp}) * r_sine;
        if (w_tick) begin
            r_acc <= '0;
        end else if (r_s3_valid) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
    end

    // Scale by normalization gain, then output gain
    assign w_n = N_W'(r_p1 >>> 15);

    always_ff @(posedge i_clk) begin
        if (r_state == ST_NORM) begin
            r_p1 <= r_acc * $signed({1'b0, w_cfg.norm_gain});
        end
        if (r_state == ST_GAIN) begin
            r_p2 <= w_n * $signed({1'b0, w_cfg.out_gain});
        end
    end

    // Saturate to 16 bits
    always_comb begin
        w_v    = V_W'(r_p2 >>> 30);
        w_v_hi = w_v[V_W-1:15];
        w_sat  = !((&w_v_hi) || !(|w_v_hi));
        if (!w_sat) begin
            w_sample = w_v[15:0];
        end else if (w_v[V_W-1]) begin
            w_sample = SAMPLE_MIN;
        end else begin
            w_sample = SAMPLE_MAX;
        end
    end

    // Result register: hold until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_sample <= w_sample;
            r_out_used   <= 4'(r_k);
            r_out_sat    <= w_sat;
        end
    end

    assign i_req.ready         = w_req_ready;
    assign o_res.valid         = r_out_valid;
    assign o_res.sample        = r_out_sample;
    assign o_res.partials_used = r_out_used;
    assign o_res.saturated     = r_out_sat;

    // Scaling starts only once every harmonic is in the sum
    a_drained_before_scale: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_NORM) |-> w_pipe_empty
    ) else $error("scaling started with harmonics still in flight");

    // Harmonic pipeline runs only inside a tick
    a_pipe_in_tick: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid |-> (r_state == ST_ISSUE || r_state == ST_DRAIN)
    ) else $error("phase write back outside a tick");

    // Saturated flag agrees with a clipped sample
    a_sat_value: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.saturated) |->
            (o_res.sample == SAMPLE_MAX || o_res.sample == SAMPLE_MIN)
    ) else $error("saturated result without a clipped sample");

endmodule

@@ dv/additive_sine_oscillator_test.sv @@
// ----------------------------------------------------------------------------
// additive_sine_oscillator_test: self-checking bench for the sine oscillator
// Feeds tick, amplitude-write, phase-clear and unused requests through the
// request channel and drives the APB registers between phases. Each tick is
// predicted by a local harmonic model with its own quarter-wave sine table.
// Every result is compared in order, field by field, under random idling.
// ----------------------------------------------------------------------------
module additive_sine_oscillator_test
    import aso_pkg::*;
();

    localparam logic [1:0]  REQ_UNUSED     = 2'd3;
    localparam int          LUT_SIZE       = 1 << TABLE_BITS;
    localparam int          LUT_QUARTER    = LUT_SIZE / 4;
    localparam logic [63:0] HALF_PI_FIX    = 64'd1686629713;
    localparam logic [63:0] HALF_FIX       = 64'd536870912;
    localparam int          LONG_HOLD      = 300;
    localparam int          SETTLE_CYCLES  = 24;
    localparam int          WATCHDOG_LIMIT = 4000;
    localparam int          RANDOM_PHASES  = 8;
    localparam int          PHASE_ITEMS    = 88;

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  index;
        logic [15:0] amp;
    } osc_req_t;

    typedef struct packed {
        logic [15:0] sample;
        logic [3:0]  used;
        logic        clipped;
    } osc_out_t;

    logic              i_clk   = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [ADDR_W-1:0] paddr   = '0;
    logic [31:0]       pwdata  = '0;
    logic [31:0]       prdata;
    logic              pready;

    aso_req_if req_if();
    aso_res_if res_if();

    additive_sine_oscillator uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_req   (req_if),
        .o_res   (res_if)
    );

    // Harmonic model state
    logic [31:0] osc_phase [PARTIALS];
    logic [15:0] osc_amp [PARTIALS];
    logic [31:0] step_reg;
    logic [15:0] out_gain_reg;
    logic [15:0] norm_gain_reg;
    shortint     sine_lut [LUT_SIZE];

    osc_req_t pending_reqs [$];
    osc_out_t sample_expect [$];
    osc_req_t cur_req;

    int queued_reqs   = 0;
    int accepted_reqs = 0;
    int errors        = 0;
    int ticks         = 0;
    int clip_ticks    = 0;
    int cutoff_ticks  = 0;
    int amp_writes    = 0;
    int clears        = 0;
    int unused_reqs   = 0;
    int cfg_writes    = 0;

    // Traffic shaping
    bit no_idle     = 1'b0;
    int hold_asked  = 0;
    int hold_served = 0;
    int src_gap     = 0;
    bit src_bursty  = 1'b1;
    int sink_gap    = 0;
    int sink_hold   = 0;
    bit sink_bursty = 1'b1;
    int idle_cycles = 0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Quarter-wave magnitude, Taylor series in Q30, rounded to Q1.15
    function automatic int quarter_mag(input int unsigned r);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned sum;
        longint unsigned v;
        x    = (HALF_PI_FIX * 64'(r)) / 64'(LUT_QUARTER);
        x2   = (x * x) >> 30;
        term = x;
        sum  = x;
        for (int n = 1; n <= 10; n++) begin
            term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
            if (n % 2 == 1) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        v = (sum * 64'd32767 + HALF_FIX) >> 30;
        if (v > 64'd32767) begin
            v = 64'd32767;
        end
        return int'(v);
    endfunction

    // Unfold the quarter wave over the full period
    function automatic void build_sine_lut();
        int unsigned quad;
        int unsigned rem;
        int          mag;
        for (int unsigned i = 0; i < LUT_SIZE; i++) begin
            quad = i / LUT_QUARTER;
            rem  = i % LUT_QUARTER;
            mag  = quad[0] ? quarter_mag(LUT_QUARTER - rem) : quarter_mag(rem);
            sine_lut[i] = shortint'(quad[1] ? -mag : mag);
        end
    endfunction

    // Advance the harmonic model by one accepted request
    function automatic void apply_request(input osc_req_t rq);
        longint      acc;
        longint      nq;
        longint      vq;
        int unsigned k;
        logic [31:0] ph;
        osc_out_t    res;
        case (rq.kind)
            REQ_WRITE_AMP: begin
                if (rq.index >= 1 && rq.index <= PARTIALS) begin
                    osc_amp[rq.index - 1] = rq.amp;
                end
                amp_writes++;
            end
            REQ_CLEAR: begin
                foreach (osc_phase[i]) begin
                    osc_phase[i] = '0;
                end
                clears++;
            end
            REQ_TICK: begin
                acc = 0;
                k   = 1;
                // sum harmonics up to the Nyquist cutoff
                while (k <= PARTIALS && 64'(k) * 64'(step_reg) < 64'h8000_0000) begin
                    ph  = osc_phase[k - 1];
                    acc = acc + longint'(osc_amp[k - 1])
                              * longint'(sine_lut[ph >> (32 - TABLE_BITS)]);
                    osc_phase[k - 1] = ph + k * step_reg;
                    k++;
                end
                nq = (acc * longint'(norm_gain_reg)) >>> 15;
                vq = (nq * longint'(out_gain_reg)) >>> 30;
                res.clipped = 1'b0;
                if (vq > 32767) begin
                    vq = 32767;
                    res.clipped = 1'b1;
                end else if (vq < -32768) begin
                    vq = -32768;
                    res.clipped = 1'b1;
                end
                res.sample = vq[15:0];
                res.used   = 4'(k - 1);
                sample_expect.push_back(res);
                ticks++;
                if (res.clipped) begin
                    clip_ticks++;
                end
                if (k == 1) begin
                    cutoff_ticks++;
                end
            end
            default: begin
                unused_reqs++;
            end
        endcase
    endfunction

    // Request driver: hold each request until accepted, idle in bursts
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else begin
            if (req_if.valid && req_if.ready) begin
                apply_request(cur_req);
                accepted_reqs++;
            end
            if (!req_if.valid || req_if.ready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    req_if.valid <= 1'b0;
                end else if (pending_reqs.size() == 0) begin
                    req_if.valid <= 1'b0;
                end else if (!no_idle && src_bursty && $urandom_range(0, 5) == 0) begin
                    src_gap = $urandom_range(1, 11) - 1;
                    req_if.valid <= 1'b0;
                end else begin
                    cur_req = pending_reqs.pop_front();
                    req_if.req_type        <= cur_req.kind;
                    req_if.partial_index   <= cur_req.index;
                    req_if.amplitude_value <= cur_req.amp;
                    req_if.valid           <= 1'b1;
                end
            end
            if ($urandom_range(0, 63) == 0) begin
                src_bursty = !src_bursty;
            end
        end
    end

    // Result monitor: check against the oldest expected sample, stall at random
    always @(posedge i_clk) begin
        osc_out_t want;
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                if (sample_expect.size() == 0) begin
                    $error("unexpected result: sample %0d partials_used %0d saturated %0b",
                           res_if.sample, res_if.partials_used, res_if.saturated);
                    errors++;
                end else begin
                    want = sample_expect.pop_front();
                    if (res_if.sample !== want.sample) begin
                        $error("sample: expected %0d, got %0d",
                               $signed(want.sample), res_if.sample);
                        errors++;
                    end
                    if (res_if.partials_used !== want.used) begin
                        $error("partials_used: expected %0d, got %0d",
                               want.used, res_if.partials_used);
                        errors++;
                    end
                    if (res_if.saturated !== want.clipped) begin
                        $error("saturated: expected %0b, got %0b",
                               want.clipped, res_if.saturated);
                        errors++;
                    end
                end
            end
            if (hold_served != hold_asked) begin
                hold_served = hold_asked;
                sink_hold   = LONG_HOLD;
            end
            if (sink_hold > 0) begin
                sink_hold--;
                res_if.ready <= 1'b0;
            end else if (sink_gap > 0) begin
                sink_gap--;
                res_if.ready <= 1'b0;
            end else if (!no_idle && sink_bursty && $urandom_range(0, 4) == 0) begin
                sink_gap = $urandom_range(1, 11) - 1;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= 1'b1;
            end
            if ($urandom_range(0, 63) == 0) begin
                sink_bursty = !sink_bursty;
            end
        end
    end

    // Watchdog: end the run after too long without any transfer
    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)
                || (psel && penable && pwrite && pready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic queue_request(input logic [1:0] kind, input logic [3:0] index,
                                 input logic [15:0] amp);
        osc_req_t rq;
        rq.kind  = kind;
        rq.index = index;
        rq.amp   = amp;
        pending_reqs.push_back(rq);
        queued_reqs++;
    endtask

    // APB write: setup cycle, then access cycle
    task automatic write_reg(input logic [1:0] reg_id, input logic [31:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({reg_id, 2'b00});
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (reg_id)
            REG_PHASE_STEP: step_reg      = value;
            REG_OUT_GAIN:   out_gain_reg  = value[15:0];
            REG_NORM_GAIN:  norm_gain_reg = value[15:0];
            default: ;
        endcase
        cfg_writes++;
    endtask

    task automatic set_config(input logic [31:0] step, input logic [15:0] og,
                              input logic [15:0] ng);
        write_reg(REG_PHASE_STEP, step);
        write_reg(REG_OUT_GAIN, {16'd0, og});
        write_reg(REG_NORM_GAIN, {16'd0, ng});
    endtask

    // Wait until every request is taken and every sample checked, then settle
    task automatic wait_idle();
        @(posedge i_clk);
        while (accepted_reqs != queued_reqs || sample_expect.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic pick_config();
        logic [31:0] step;
        logic [15:0] og;
        logic [15:0] ng;
        case ($urandom_range(0, 5))
            0, 1, 2: step = $urandom_range(0, 32'h1000_0000);
            3:       step = $urandom_range(0, 32'h4000_0000);
            4:       step = $urandom;
            default: step = 32'h8000_0000 / $urandom_range(1, 9) - $urandom_range(0, 1);
        endcase
        og = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 32768));
        ng = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 32768));
        set_config(step, og, ng);
    endtask

    task automatic queue_random_request();
        int          pick;
        logic [3:0]  idx;
        logic [15:0] amp;
        pick = $urandom_range(0, 99);
        if (pick < 62) begin
            queue_request(REQ_TICK, 4'($urandom), 16'($urandom));
        end else if (pick < 87) begin
            idx = ($urandom_range(0, 6) == 0) ? 4'($urandom) : 4'($urandom_range(1, PARTIALS));
            amp = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 32768));
            queue_request(REQ_WRITE_AMP, idx, amp);
        end else if (pick < 93) begin
            queue_request(REQ_CLEAR, 4'($urandom), 16'($urandom));
        end else begin
            queue_request(REQ_UNUSED, 4'($urandom), 16'($urandom));
        end
    endtask

    initial begin
        req_if.valid           = 1'b0;
        req_if.req_type        = REQ_TICK;
        req_if.partial_index   = '0;
        req_if.amplitude_value = '0;
        res_if.ready           = 1'b0;

        // model state after reset
        build_sine_lut();
        foreach (osc_phase[i]) begin
            osc_phase[i] = '0;
            osc_amp[i]   = '0;
        end
        osc_amp[0]    = UNITY_Q15;
        step_reg      = '0;
        out_gain_reg  = UNITY_Q15;
        norm_gain_reg = UNITY_Q15;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // zero step: all harmonics summed, out-of-range writes and unused type dropped
        set_config(32'h0, UNITY_Q15, UNITY_Q15);
        queue_request(REQ_TICK, 4'h0, 16'h0000);
        queue_request(REQ_WRITE_AMP, 4'd0, 16'hFFFF);
        queue_request(REQ_WRITE_AMP, 4'd9, 16'hFFFF);
        queue_request(REQ_WRITE_AMP, 4'd15, 16'hFFFF);
        queue_request(REQ_UNUSED, 4'hF, 16'hFFFF);
        queue_request(REQ_TICK, 4'hF, 16'hFFFF);
        wait_idle();

        // quarter-circle step: fundamental only, walk the cardinal points, then clear
        set_config(32'h4000_0000, UNITY_Q15, UNITY_Q15);
        repeat (4) queue_request(REQ_TICK, 4'h0, 16'h0000);
        queue_request(REQ_CLEAR, 4'h0, 16'h0000);
        queue_request(REQ_TICK, 4'h0, 16'h0000);
        wait_idle();

        // full-scale amplitudes and gains above unity: drive into clipping
        set_config(32'h1300_0000, 16'hFFFF, 16'hFFFF);
        queue_request(REQ_WRITE_AMP, 4'd1, 16'hFFFF);
        queue_request(REQ_WRITE_AMP, 4'd2, UNITY_Q15);
        queue_request(REQ_WRITE_AMP, 4'(PARTIALS), 16'h7FFF);
        repeat (5) queue_request(REQ_TICK, 4'h0, 16'h0000);
        wait_idle();

        // cutoff at the fundamental and zero gains
        set_config(32'h8000_0000, 16'h0000, 16'h0000);
        queue_request(REQ_TICK, 4'h0, 16'h0000);
        wait_idle();
        set_config(32'hFFFF_FFFF, UNITY_Q15, UNITY_Q15);
        queue_request(REQ_TICK, 4'h0, 16'h0000);
        wait_idle();
        set_config(32'h7FFF_FFFF, 16'h0000, 16'h0000);
        queue_request(REQ_TICK, 4'h0, 16'h0000);
        wait_idle();

        // random phases, one long result stall, no idling in the last one
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            pick_config();
            if (p == 2) begin
                hold_asked++;
            end
            if (p == RANDOM_PHASES - 1) begin
                no_idle = 1'b1;
            end
            repeat (PHASE_ITEMS) queue_random_request();
            wait_idle();
        end

        if (sample_expect.size() != 0) begin
            $error("%0d expected samples never arrived", sample_expect.size());
            errors++;
        end
        $display("Checked %0d ticks (%0d clipped, %0d cut off at the fundamental),",
                 ticks, clip_ticks, cutoff_ticks);
        $display("%0d amplitude writes, %0d clears, %0d unused requests, %0d register writes.",
                 amp_writes, clears, unused_reqs, cfg_writes);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

@@ additive_sine_oscillator.f @@
rtl/aso_pkg.sv
rtl/aso_if.sv
rtl/aso_apb_regs.sv
rtl/additive_sine_oscillator.sv
dv/additive_sine_oscillator_test.sv
